/* rtl/core/nbga_pkg.sv */
`default_nettype none
package nbga_pkg;

	localparam int MAX_BODIES_DEF = 64;

	// Unit datapath and operand widths
	localparam int UW       = 128;
	localparam int MAG_W    = 33;
	localparam int R2_W     = 66;
	localparam int R_W      = 35;
	localparam int DEN_W    = 101;
	localparam int GM_W     = 64;
	localparam int NUM_W    = 113;
	localparam int Q_W      = 53;
	localparam int ACC_W    = 64;
	localparam int OUT_W    = 48;
	localparam int SQ_STEPS = 35;
	localparam int SQ_X_W   = 2 * SQ_STEPS;
	localparam int CNT_W    = 7;

	// Unit operations
	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	// Item modes
	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// Register indexes
	localparam logic [1:0] REG_GRAV   = 2'd0;
	localparam logic [1:0] REG_THR    = 2'd1;
	localparam logic [1:0] REG_BODIES = 2'd2;

	typedef struct packed {
		logic               mode;
		logic [5:0]         body_id;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [31:0]        body_mass;
	} in_t;

	typedef struct packed {
		logic [5:0]         queried_id;
		logic signed [31:0] dx_rate;
		logic signed [31:0] dy_rate;
		logic signed [31:0] dz_rate;
		logic signed [47:0] acc_x;
		logic signed [47:0] acc_y;
		logic signed [47:0] acc_z;
		logic               saturated;
		logic               index_invalid;
	} out_t;

	typedef struct packed {
		logic [2:0][31:0] pos;
		logic [2:0][31:0] vel;
		logic [31:0]      mass;
	} body_t;

	typedef struct packed {
		logic       go;
		logic [1:0] op;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic ovf;
	} unit_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/nbga_store.sv */
`default_nettype none
module nbga_store import nbga_pkg::*; #(
	parameter int MAX_BODIES = MAX_BODIES_DEF,
	localparam int AW = $clog2(MAX_BODIES)
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] wr_addr,
	input  wire body_t         wr_data,
	input  wire logic [AW-1:0] rd_addr,
	output body_t              rd_data
);

	body_t mem_q [MAX_BODIES];
	body_t rd_q;

	// Write one body, read one body a cycle with registered data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
`default_nettype wire

/* rtl/core/nbga_unit.sv */
`default_nettype none
module nbga_unit import nbga_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire unit_req_t     req,
	input  wire logic [UW-1:0] opa,
	input  wire logic [UW-1:0] opb,
	output unit_rsp_t          rsp,
	output logic [UW-1:0]      res
);

	logic             busy_q;
	logic [1:0]       op_q;
	logic [CNT_W-1:0] cnt_q;
	logic [UW-1:0]    acc_q, a_q, b_q, quo_q;
	logic [UW-1:0]    rem_div, rem_sq, trial;
	logic             ge_div, ge_sq, done, ovf;

	// Next remainder candidates for divide and square root steps
	always_comb begin
		rem_div = {acc_q[UW-2:0], a_q[NUM_W-1]};
		ge_div  = rem_div >= b_q;
		rem_sq  = {acc_q[UW-3:0], a_q[SQ_X_W-1 -: 2]};
		trial   = {quo_q[UW-3:0], 2'b01};
		ge_sq   = rem_sq >= trial;
		ovf     = |quo_q[UW-1:Q_W-1];
		done    = busy_q && ((op_q == OP_MUL) ? (b_q == '0) : (cnt_q == '0));
	end

	// Advance one bit or digit a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.go) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			op_q  <= req.op;
			a_q   <= opa;
			b_q   <= opb;
			acc_q <= '0;
			quo_q <= '0;
			cnt_q <= (req.op == OP_DIV) ? CNT_W'(NUM_W) : CNT_W'(SQ_STEPS);
		end else if (busy_q && !done) begin
			unique case (op_q)
				OP_MUL: begin
					if (b_q[0]) acc_q <= acc_q + a_q;
					a_q <= a_q << 1;
					b_q <= b_q >> 1;
				end
				OP_DIV: begin
					acc_q <= ge_div ? rem_div - b_q : rem_div;
					quo_q <= {quo_q[UW-2:0], ge_div};
					a_q   <= a_q << 1;
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					acc_q <= ge_sq ? rem_sq - trial : rem_sq;
					quo_q <= {quo_q[UW-2:0], ge_sq};
					a_q   <= a_q << 2;
					cnt_q <= cnt_q - 1'b1;
				end
			endcase
		end
	end

	// Present the result; clip the quotient to the term cap
	always_comb begin
		unique case (op_q)
			OP_MUL:  res = acc_q;
			OP_DIV:  res = ovf ? UW'({(Q_W-1){1'b1}}) : quo_q;
			default: res = quo_q;
		endcase
		rsp.done = done;
		rsp.ovf  = ovf;
	end

	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.go |-> !busy_q) else $error("unit started while busy");
	a_div_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && op_q == OP_DIV) |-> (res[UW-1:Q_W] == '0))
		else $error("quotient above term cap");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !req.go) |=> !busy_q) else $error("unit still busy after done");

endmodule
`default_nettype wire

/* rtl/core/nbody_gravity_accel_3d_top.sv */
`default_nettype none
// Direct-sum 3D gravitational acceleration, fixed point.
// Command channel: an item is taken when start is high and busy is low.
// A load (mode 0) writes one body into the store in that cycle and leaves
// busy low, so a new item may follow at once; it gives no result.
// A query (mode 1) for an index at or above the count in use gives its
// result with index_invalid set on the next cycle, busy stays low.
// A valid query raises busy and walks every other body in use through one
// shared bit-serial unit (shift-add multiply, restoring divide, digit
// square root). Per pair: three squares, a root, the r^3 and G*m
// products, then per kept axis a product and a divide; each operation
// passes through the GO and WAIT handshake states.
// The result appears on rsp for exactly one cycle with rsp_valid high and
// must be taken then; busy falls in that same cycle.
// Configuration: cfg_ready is always high; write only while busy is low.
// Reset restores G = 1.0, threshold 0 and two bodies; store contents are
// undefined until loaded.
module nbody_gravity_accel_3d_top import nbga_pkg::*; #(
	parameter int MAX_BODIES = MAX_BODIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire in_t         cmd,
	output logic             rsp_valid,
	output out_t             rsp,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	localparam int AW = $clog2(MAX_BODIES);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_OWN_LT = 4'd1;
	localparam logic [3:0] ST_PAIR   = 4'd2;
	localparam logic [3:0] ST_OTH_LT = 4'd3;
	localparam logic [3:0] ST_GO     = 4'd4;
	localparam logic [3:0] ST_WAIT   = 4'd5;
	localparam logic [3:0] ST_DONE   = 4'd6;

	localparam logic [2:0] P_SQ   = 3'd0;
	localparam logic [2:0] P_SQRT = 3'd1;
	localparam logic [2:0] P_DEN  = 3'd2;
	localparam logic [2:0] P_GM   = 3'd3;
	localparam logic [2:0] P_NUM  = 3'd4;
	localparam logic [2:0] P_DIV  = 3'd5;

	logic [3:0]  state_q;
	logic [2:0]  step_q;
	logic [1:0]  ax_q;
	logic [31:0] grav_q;
	logic [15:0] thr_q;
	logic [6:0]  bodies_q;
	logic [6:0]  n_w;
	logic [6:0]  j_q;
	logic [5:0]  id_q;
	logic        clip_q;
	logic        rsp_valid_q;
	out_t        rsp_q;

	logic [2:0][31:0]             own_pos_q, own_vel_q;
	logic [2:0][MAG_W-1:0]        mag_q;
	logic [2:0]                   neg_q, kept_q;
	logic [2:0][ACC_W-1:0]        acc_q;
	logic [31:0]                  mass_q;
	logic [R2_W-1:0]              r2_q;
	logic [R_W-1:0]               r_q;
	logic [DEN_W-1:0]             den_q;
	logic [GM_W-1:0]              gm_q;
	logic [NUM_W-1:0]             num_q;

	logic          accept, we;
	logic [AW-1:0] rd_addr;
	body_t         wr_body, rd_body;
	unit_req_t     u_req;
	unit_rsp_t     u_rsp;
	logic [UW-1:0] u_a, u_b, u_res;
	logic [2:0]    base_w;
	logic          nxt_found;
	logic [1:0]    nxt_ax;
	logic [Q_W-1:0] q_w;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign n_w       = (int'(bodies_q) < MAX_BODIES) ? bodies_q : 7'(MAX_BODIES);
	assign we        = accept && (cmd.mode == MODE_LOAD) && (int'(cmd.body_id) < MAX_BODIES);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign q_w       = u_res[Q_W-1:0];

	always_comb begin
		wr_body.pos  = {cmd.pos_z, cmd.pos_y, cmd.pos_x};
		wr_body.vel  = {cmd.vel_z, cmd.vel_y, cmd.vel_x};
		wr_body.mass = cmd.body_mass;
		rd_addr      = (state_q == ST_IDLE) ? AW'(cmd.body_id) : AW'(j_q);
	end

	nbga_store #(.MAX_BODIES(MAX_BODIES)) u_store (
		.clk     (clk),
		.we      (we),
		.wr_addr (AW'(cmd.body_id)),
		.wr_data (wr_body),
		.rd_addr (rd_addr),
		.rd_data (rd_body)
	);

	// Pick unit operands for the current step
	always_comb begin
		u_req.go = (state_q == ST_GO);
		u_req.op = OP_MUL;
		u_a      = '0;
		u_b      = '0;
		unique case (step_q)
			P_SQ: begin
				u_a = UW'(mag_q[ax_q]);
				u_b = UW'(mag_q[ax_q]);
			end
			P_SQRT: begin
				u_req.op = OP_SQRT;
				u_a      = UW'(r2_q);
			end
			P_DEN: begin
				u_a = UW'(r2_q);
				u_b = UW'(r_q);
			end
			P_GM: begin
				u_a = UW'(grav_q);
				u_b = UW'(mass_q);
			end
			P_NUM: begin
				u_a = UW'(gm_q);
				u_b = UW'(mag_q[ax_q]);
			end
			P_DIV: begin
				u_req.op = OP_DIV;
				u_a      = UW'(num_q);
				u_b      = UW'(den_q);
			end
			default: begin
				u_a = '0;
			end
		endcase
	end

	nbga_unit u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.opa    (u_a),
		.opb    (u_b),
		.rsp    (u_rsp),
		.res    (u_res)
	);

	// Find the next kept axis at or after the base
	always_comb begin
		base_w    = (step_q == P_GM) ? 3'd0 : {1'b0, ax_q} + 3'd1;
		nxt_found = 1'b0;
		nxt_ax    = 2'd0;
		for (int i = 2; i >= 0; i--) begin
			if (kept_q[i] && (i >= int'(base_w))) begin
				nxt_found = 1'b1;
				nxt_ax    = 2'(i);
			end
		end
	end

	function automatic logic [OUT_W:0] sat48(input logic [ACC_W-1:0] v);
		logic hi_ok;
		hi_ok = (v[ACC_W-1:OUT_W-1] == '0) || (v[ACC_W-1:OUT_W-1] == '1);
		if (hi_ok) return {1'b0, v[OUT_W-1:0]};
		else if (v[ACC_W-1]) return {1'b1, 1'b1, {(OUT_W-1){1'b0}}};
		else return {1'b1, 1'b0, {(OUT_W-1){1'b1}}};
	endfunction

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q   <= 32'd16777216;
			thr_q    <= '0;
			bodies_q <= 7'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GRAV:   grav_q   <= cfg_data;
				REG_THR:    thr_q    <= cfg_data[15:0];
				REG_BODIES: bodies_q <= cfg_data[6:0];
				default:    ;
			endcase
		end
	end

	// Sequence a query over all pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd.mode == MODE_QUERY) begin
						if (7'(cmd.body_id) >= n_w) begin
							rsp_valid_q <= 1'b1;
						end else begin
							state_q <= ST_OWN_LT;
						end
					end
				end
				ST_OWN_LT: state_q <= ST_PAIR;
				ST_PAIR: begin
					if (j_q == n_w) begin
						state_q <= ST_DONE;
					end else if (j_q != 7'(id_q)) begin
						state_q <= ST_OTH_LT;
					end
				end
				ST_OTH_LT: state_q <= ST_GO;
				ST_GO:     state_q <= ST_WAIT;
				ST_WAIT: begin
					if (u_rsp.done) begin
						priority if (step_q == P_GM || step_q == P_DIV) begin
							state_q <= nxt_found ? ST_GO : ST_PAIR;
						end else begin
							state_q <= ST_GO;
						end
					end
				end
				ST_DONE: begin
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				id_q <= cmd.body_id;
				if (accept && cmd.mode == MODE_QUERY) begin
					rsp_q               <= '0;
					rsp_q.queried_id    <= cmd.body_id;
					rsp_q.index_invalid <= 1'b1;
				end
			end
			ST_OWN_LT: begin
				own_pos_q <= rd_body.pos;
				own_vel_q <= rd_body.vel;
				j_q       <= '0;
				acc_q     <= '0;
				clip_q    <= 1'b0;
			end
			ST_PAIR: begin
				if (j_q == 7'(id_q)) j_q <= j_q + 7'd1;
			end
			ST_OTH_LT: begin
				for (int k = 0; k < 3; k++) begin
					logic signed [MAG_W-1:0] d;
					d = $signed({own_pos_q[k][31], own_pos_q[k]})
					  - $signed({rd_body.pos[k][31], rd_body.pos[k]});
					neg_q[k]  <= d[MAG_W-1];
					mag_q[k]  <= d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d);
					kept_q[k] <= (d[MAG_W-1] ? MAG_W'(-d) : MAG_W'(d)) > MAG_W'(thr_q);
				end
				mass_q <= rd_body.mass;
				r2_q   <= '0;
				step_q <= P_SQ;
				ax_q   <= 2'd0;
			end
			ST_WAIT: begin
				if (u_rsp.done) begin
					unique case (step_q)
						P_SQ: begin
							r2_q <= r2_q + R2_W'(u_res);
							if (ax_q == 2'd2) step_q <= P_SQRT;
							else ax_q <= ax_q + 2'd1;
						end
						P_SQRT: begin
							r_q    <= R_W'(u_res);
							step_q <= P_DEN;
						end
						P_DEN: begin
							den_q  <= DEN_W'(u_res);
							step_q <= P_GM;
						end
						P_GM: begin
							gm_q   <= GM_W'(u_res);
							step_q <= P_NUM;
							ax_q   <= nxt_ax;
						end
						P_NUM: begin
							num_q  <= NUM_W'(u_res) << 16;
							step_q <= P_DIV;
						end
						P_DIV: begin
							clip_q <= clip_q | u_rsp.ovf;
							acc_q[ax_q] <= neg_q[ax_q] ? acc_q[ax_q] + ACC_W'(q_w)
							                           : acc_q[ax_q] - ACC_W'(q_w);
							step_q <= P_NUM;
							ax_q   <= nxt_ax;
						end
						default: step_q <= P_SQ;
					endcase
					if ((step_q == P_GM || step_q == P_DIV) && !nxt_found) begin
						j_q <= j_q + 7'd1;
					end
				end
			end
			ST_DONE: begin
				logic [OUT_W:0] sx, sy, sz;
				sx = sat48(acc_q[0]);
				sy = sat48(acc_q[1]);
				sz = sat48(acc_q[2]);
				rsp_q.queried_id    <= id_q;
				rsp_q.dx_rate       <= own_vel_q[0];
				rsp_q.dy_rate       <= own_vel_q[1];
				rsp_q.dz_rate       <= own_vel_q[2];
				rsp_q.acc_x         <= sx[OUT_W-1:0];
				rsp_q.acc_y         <= sy[OUT_W-1:0];
				rsp_q.acc_z         <= sz[OUT_W-1:0];
				rsp_q.saturated     <= clip_q | sx[OUT_W] | sy[OUT_W] | sz[OUT_W];
				rsp_q.index_invalid <= 1'b0;
			end
			default: ;
		endcase
	end

	a_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !busy) else $error("result shown while busy");
	a_inv_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.index_invalid) |-> !rsp.saturated)
		else $error("invalid query flagged saturated");
	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> rsp_valid) else $error("finished query gave no result");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
	import nbga_pkg::*;

	localparam int  LIMIT    = 5_000_000;
	localparam int  SLOTS    = 64;
	localparam longint TERM_CAP = (longint'(1) << 52) - 1;
	localparam longint ACC_HI   = (longint'(1) << 47) - 1;
	localparam longint ACC_LO   = -(longint'(1) << 47);

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	in_t         cmd;
	logic        rsp_valid;
	out_t        rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	// shadow of the block's registers and body store
	logic [31:0] grav_shadow;
	logic [15:0] thr_shadow;
	logic [6:0]  count_shadow;
	in_t         body_shadow [SLOTS];

	out_t        pending_results [$];
	int          errors;
	int          cycles;
	int          burst_left;
	bit          no_gaps;

	nbody_gravity_accel_3d_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// bail out if the run hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	function automatic longint axis_pos(in_t b, int k);
		case (k)
			0: axis_pos = longint'($signed(b.pos_x));
			1: axis_pos = longint'($signed(b.pos_y));
			default: axis_pos = longint'($signed(b.pos_z));
		endcase
	endfunction

	// work out the derivatives of one body from the shadow store
	function automatic out_t predict_accel(logic [5:0] id);
		out_t        r;
		int          n;
		longint      d [3];
		longint      sum [3];
		logic [127:0] mag [3];
		logic [127:0] r2, root, cand, den, gm, num, q;
		bit          clip;
		r = '0;
		r.queried_id = id;
		n = (count_shadow > SLOTS) ? SLOTS : count_shadow;
		if (id >= n) begin
			r.index_invalid = 1'b1;
			return r;
		end
		clip = 1'b0;
		for (int k = 0; k < 3; k++) sum[k] = 0;
		for (int j = 0; j < n; j++) begin
			if (j == id) continue;
			r2 = '0;
			for (int k = 0; k < 3; k++) begin
				d[k] = axis_pos(body_shadow[id], k) - axis_pos(body_shadow[j], k);
				mag[k] = (d[k] < 0) ? 128'(-d[k]) : 128'(d[k]);
				r2 += mag[k] * mag[k];
			end
			// integer square root, one bit at a time
			root = '0;
			for (int b = 34; b >= 0; b--) begin
				cand = root | (128'd1 << b);
				if (cand * cand <= r2) root = cand;
			end
			den = r2 * root;
			gm = 128'(grav_shadow) * 128'(body_shadow[j].body_mass);
			for (int k = 0; k < 3; k++) begin
				if (mag[k] <= 128'(thr_shadow)) continue;
				num = (gm * mag[k]) << 16;
				q = num / den;
				if (q > 128'(TERM_CAP)) begin
					q = 128'(TERM_CAP);
					clip = 1'b1;
				end
				if (d[k] > 0) sum[k] -= longint'(q[63:0]);
				else sum[k] += longint'(q[63:0]);
			end
		end
		// clip the sums to the output range
		for (int k = 0; k < 3; k++) begin
			if (sum[k] > ACC_HI) begin
				sum[k] = ACC_HI;
				clip = 1'b1;
			end
			if (sum[k] < ACC_LO) begin
				sum[k] = ACC_LO;
				clip = 1'b1;
			end
		end
		r.dx_rate = body_shadow[id].vel_x;
		r.dy_rate = body_shadow[id].vel_y;
		r.dz_rate = body_shadow[id].vel_z;
		r.acc_x = sum[0][47:0];
		r.acc_y = sum[1][47:0];
		r.acc_z = sum[2][47:0];
		r.saturated = clip;
		return r;
	endfunction

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %h, got %h", name, exp_v, act_v);
			errors++;
		end
	endtask

	// compare every result beat with the oldest prediction
	always @(posedge clk) begin
		out_t e;
		if (arst_n && rsp_valid) begin
			if (pending_results.size() == 0) begin
				$error("result for id %0d with nothing pending", rsp.queried_id);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("queried_id", e.queried_id, rsp.queried_id);
				check_field("dx_rate", e.dx_rate, rsp.dx_rate);
				check_field("dy_rate", e.dy_rate, rsp.dy_rate);
				check_field("dz_rate", e.dz_rate, rsp.dz_rate);
				check_field("acc_x", e.acc_x, rsp.acc_x);
				check_field("acc_y", e.acc_y, rsp.acc_y);
				check_field("acc_z", e.acc_z, rsp.acc_z);
				check_field("saturated", e.saturated, rsp.saturated);
				check_field("index_invalid", e.index_invalid, rsp.index_invalid);
			end
		end
	end

	// send one beat; a load updates the shadow, a query queues the expected result
	task automatic send_item(in_t item);
		cmd <= item;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		if (item.mode == MODE_LOAD) body_shadow[item.body_id] = item;
		else pending_results.push_back(predict_accel(item.body_id));
		// bursts with random gaps between them
		if (!no_gaps) begin
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 8);
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		if (start) start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_GRAV:   grav_shadow = value;
			REG_THR:    thr_shadow = value[15:0];
			REG_BODIES: count_shadow = value[6:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] g, logic [15:0] thr, logic [6:0] n);
		write_reg(REG_GRAV, g);
		write_reg(REG_THR, {16'd0, thr});
		write_reg(REG_BODIES, {25'd0, n});
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: rand_coord = $urandom();
			1: rand_coord = $urandom_range(0, 1 << 21) - (1 << 20);
			default: rand_coord = $urandom_range(0, 1 << 24) - (1 << 23);
		endcase
	endfunction

	function automatic in_t make_load(logic [5:0] id);
		in_t b;
		b.mode      = MODE_LOAD;
		b.body_id   = id;
		b.pos_x     = rand_coord();
		b.pos_y     = rand_coord();
		b.pos_z     = rand_coord();
		b.vel_x     = $urandom();
		b.vel_y     = $urandom();
		b.vel_z     = $urandom();
		b.body_mass = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 1 << 20);
		return b;
	endfunction

	function automatic in_t make_query(logic [5:0] id);
		in_t q;
		q = make_load(id);
		q.mode = MODE_QUERY;
		return q;
	endfunction

	function automatic in_t make_body(logic [5:0] id, logic [31:0] x, logic [31:0] y,
		logic [31:0] z, logic [31:0] m);
		in_t b;
		b = make_load(id);
		b.pos_x = x;
		b.pos_y = y;
		b.pos_z = z;
		b.body_mass = m;
		return b;
	endfunction

	// fill every slot so no query ever reads an unwritten entry
	task automatic test_fill_store();
		for (int i = 0; i < SLOTS; i++) send_item(make_load(i[5:0]));
		wait_idle();
	endtask

	task automatic test_directed();
		in_t b;
		b = make_body(6'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000);
		b.vel_x = 32'h7FFF_FFFF;
		b.vel_y = 32'h8000_0000;
		b.vel_z = 32'd0;
		send_item(b);
		send_item(make_body(6'd1, 32'h0001_0000, 32'd0, 32'd0, 32'h0001_0000));
		send_item(make_body(6'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_item(make_body(6'd3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		send_item(make_body(6'd4, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF));
		// default registers: two bodies, unit G
		send_item(make_query(6'd0));
		send_item(make_query(6'd1));
		send_item(make_query(6'd2));
		send_item(make_query(6'd63));
		// hold off until every result is in
		wait_idle();
		// largest G: a close heavy neighbour clips the term and the sum
		set_config(32'hFFFF_FFFF, 16'd0, 7'd5);
		for (int i = 0; i < 5; i++) send_item(make_query(i[5:0]));
		wait_idle();
		set_config(32'd0, 16'hFFFF, 7'd5);
		send_item(make_query(6'd0));
		send_item(make_query(6'd4));
		wait_idle();
		set_config(32'h0100_0000, 16'hFFFF, 7'd5);
		send_item(make_query(6'd0));
		wait_idle();
		// a count of zero makes every index invalid
		write_reg(REG_BODIES, 32'd0);
		send_item(make_query(6'd0));
		wait_idle();
		write_reg(REG_BODIES, 32'd1);
		send_item(make_query(6'd0));
		send_item(make_query(6'd1));
		wait_idle();
		// count above the store size is taken as the full store
		set_config(32'h0100_0000, 16'd0, 7'd127);
		send_item(make_query(6'd5));
		wait_idle();
	endtask

	task automatic test_random_phases();
		logic [31:0] g;
		logic [15:0] thr;
		logic [6:0]  n;
		int          items, lim;
		for (int p = 0; p < 14; p++) begin
			case ($urandom_range(0, 3))
				0: g = 32'h0100_0000;
				1: g = 32'hFFFF_FFFF;
				2: g = $urandom_range(0, 1 << 20);
				default: g = $urandom();
			endcase
			case ($urandom_range(0, 3))
				0: thr = 16'd0;
				1: thr = 16'hFFFF;
				default: thr = 16'($urandom());
			endcase
			// keep the walks short, with one full store and one oversized count
			if (p == 5) n = 7'd64;
			else if (p == 9) n = 7'd100;
			else n = 7'($urandom_range(2, 8));
			set_config(g, thr, n);
			no_gaps = (p % 4 == 3);
			items = (n >= 64) ? 3 : 17;
			lim = (n >= 64) ? 63 : n - 1;
			for (int i = 0; i < items; i++) begin
				if ($urandom_range(0, 9) < 4) begin
					send_item(make_load(6'($urandom_range(0, 63))));
				end else if ($urandom_range(0, 9) == 0) begin
					send_item(make_query(6'($urandom_range(0, 63))));
				end else begin
					send_item(make_query(6'($urandom_range(0, lim))));
				end
			end
			wait_idle();
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		burst_left = 4;
		no_gaps = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_GRAV;
		cfg_data = '0;
		grav_shadow = 32'h0100_0000;
		thr_shadow = '0;
		count_shadow = 7'd2;
		for (int i = 0; i < SLOTS; i++) body_shadow[i] = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fill_store();
		test_directed();
		test_random_phases();
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
